FILE: rtl/core/mcsql_pkg.sv
// Package for the queue lock manager: opcodes, node roles, result codes,
// controller states and the result record. No dependencies.
package mcsql_pkg;

  // Request opcodes.
  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  // Role of a node with respect to the lock.
  typedef enum logic [1:0] {
    ROLE_IDLE    = 2'd0,
    ROLE_WAITING = 2'd1,
    ROLE_HOLDING = 2'd2
  } role_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_FREED   = 3'd2,
    ST_HANDED  = 3'd3,
    ST_REFUSED = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SECOND,
    S_FINISH
  } state_e;

  // Width of the node number on the ports.
  localparam int unsigned NodeW = 4;

  // One result transaction.
  typedef struct packed {
    status_e          status;
    logic [NodeW-1:0] grant_node;
    logic [NodeW-1:0] predecessor_node;
  } result_t;

endpackage

FILE: rtl/core/mcs_queue_lock_manager.sv
// Queue lock manager: after an input transaction is accepted, the memory read is registered,
// the execute step runs, queued and handed-over requests take an optional second memory write,
// and the result is loaded into the output register, which waits while the output is stalled.
// A new request is accepted only after the result of the previous one has been loaded.
// Reset empties the tail and clears the role valid bits at once; no clearing pass is run.
// Successor links hold no reset value; a link is always written before it is read.
module mcs_queue_lock_manager
  import mcsql_pkg::*;
#(
  parameter int unsigned NODES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             in_opcode_i,
  input  logic [NodeW-1:0] in_requester_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       out_status_o,
  output logic [NodeW-1:0] out_grant_node_o,
  output logic [NodeW-1:0] out_predecessor_node_o
);

  // Only requesters that fit the port can ever use the lock.
  localparam int unsigned Depth = (NODES < (1 << NodeW)) ? NODES : (1 << NodeW);
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [NodeW:0] Limit = (NodeW + 1)'(Depth);

  // Controller and per-request registers.
  state_e            state_q, state_d;
  op_e               op_q;
  logic [IdxW-1:0]   who_q;
  logic              in_range_q;
  logic              in_accept;
  logic [IdxW-1:0]   in_addr;

  // Lock state outside the memories.
  logic              tail_vld_q, tail_vld_d;
  logic [IdxW-1:0]   tail_q, tail_d;
  logic [Depth-1:0]  role_vld_q;

  // Memories and their registered read data.
  role_e             role_mem [Depth];
  logic [IdxW:0]     link_mem [Depth];
  role_e             role_rd_q;
  logic              role_vld_rd_q;
  logic [IdxW:0]     link_rd_q;
  role_e             role_cur;

  // Memory write ports.
  logic              role_we;
  logic [IdxW-1:0]   role_wa;
  role_e             role_wd;
  logic              link_we;
  logic [IdxW-1:0]   link_wa;
  logic [IdxW:0]     link_wd;

  // Second write target, result and output register.
  logic [IdxW-1:0]   sec_addr_q, sec_addr_d;
  result_t           res_q, res_d;
  logic              out_load;
  logic              out_valid_q;
  result_t           out_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_addr   = in_requester_i[IdxW-1:0];
  assign role_cur  = role_vld_rd_q ? role_rd_q : ROLE_IDLE;

  // Memory writes and the read issued when a transaction is accepted. Each
  // request finishes its writes before the next one is accepted, so reads
  // never overlap a pending write.
  always_ff @(posedge clk_i) begin
    if (role_we) begin
      role_mem[role_wa] <= role_wd;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (in_accept) begin
      role_rd_q     <= role_mem[in_addr];
      link_rd_q     <= link_mem[in_addr];
      role_vld_rd_q <= role_vld_q[in_addr];
      op_q          <= op_e'(in_opcode_i);
      who_q         <= in_addr;
      in_range_q    <= ({1'b0, in_requester_i} < Limit);
    end
    sec_addr_q <= sec_addr_d;
    res_q      <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tail_vld_q  <= 1'b0;
      tail_q      <= '0;
      role_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      tail_vld_q <= tail_vld_d;
      tail_q     <= tail_d;
      if (role_we) begin
        role_vld_q[role_wa] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Next state, memory writes and result.
  always_comb begin
    state_d    = state_q;
    tail_vld_d = tail_vld_q;
    tail_d     = tail_q;
    sec_addr_d = sec_addr_q;
    res_d      = res_q;
    role_we    = 1'b0;
    role_wa    = who_q;
    role_wd    = ROLE_IDLE;
    link_we    = 1'b0;
    link_wa    = who_q;
    link_wd    = '0;
    out_load   = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d   = '{status: ST_REFUSED, grant_node: '0, predecessor_node: '0};
        state_d = S_FINISH;
        if (in_range_q && op_q == OP_ACQUIRE && role_cur == ROLE_IDLE) begin
          // Clear own link and swap into the tail.
          link_we    = 1'b1;
          role_we    = 1'b1;
          tail_vld_d = 1'b1;
          tail_d     = who_q;
          if (!tail_vld_q) begin
            role_wd          = ROLE_HOLDING;
            res_d.status     = ST_GRANTED;
            res_d.grant_node = NodeW'(who_q);
          end else begin
            role_wd                = ROLE_WAITING;
            res_d.status           = ST_QUEUED;
            res_d.predecessor_node = NodeW'(tail_q);
            sec_addr_d             = tail_q;
            state_d                = S_SECOND;
          end
        end else if (in_range_q && op_q == OP_RELEASE && role_cur == ROLE_HOLDING) begin
          role_we = 1'b1;
          role_wd = ROLE_IDLE;
          if (!link_rd_q[IdxW]) begin
            // No successor: the holder is the tail, so the lock is freed.
            tail_vld_d   = 1'b0;
            tail_d       = '0;
            res_d.status = ST_FREED;
          end else begin
            res_d.status     = ST_HANDED;
            res_d.grant_node = NodeW'(link_rd_q[IdxW-1:0]);
            sec_addr_d       = link_rd_q[IdxW-1:0];
            state_d          = S_SECOND;
          end
        end
      end
      S_SECOND: begin
        // Link the predecessor to the requester, or promote the successor.
        if (op_q == OP_ACQUIRE) begin
          link_we = 1'b1;
          link_wa = sec_addr_q;
          link_wd = {1'b1, who_q};
        end else begin
          role_we = 1'b1;
          role_wa = sec_addr_q;
          role_wd = ROLE_HOLDING;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o            = out_valid_q;
  assign out_status_o           = out_q.status;
  assign out_grant_node_o       = out_q.grant_node;
  assign out_predecessor_node_o = out_q.predecessor_node;

`ifndef SYNTHESIS
  // A delivered result agrees with the tail: only a free leaves the queue empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_q.status != ST_REFUSED) |-> (tail_vld_q == (res_q.status != ST_FREED)))
    else $error("tail state disagrees with result status");

  // The second write step only follows the execute step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SECOND) |-> ($past(state_q) == S_EXEC))
    else $error("second write entered out of order");

  // A granted or queued requester has a valid role entry afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && (res_d.status == ST_GRANTED || res_d.status == ST_QUEUED))
      |=> role_vld_q[$past(who_q)])
    else $error("role entry not marked after acquire");

  // A queued requester never waits behind itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && res_d.status == ST_QUEUED) |-> (tail_q != who_q))
    else $error("requester queued behind itself");
`endif

endmodule
